// ===== rtl/pgl_pkg.sv =====
// Shared types, constants and table functions for the pixel Gaussian likelihood block.
// Used by every module in rtl/ except pgl_checker; depends on nothing else.
`default_nettype none

package pgl_pkg;

    localparam int COMP_MAX     = 4;
    localparam int COMPONENTS   = 4;
    localparam int COMP_W       = 16;
    localparam int TERM_W       = 48;
    localparam int SUM_W        = TERM_W + 2;
    localparam int EXP_LIMIT_W  = 33;
    localparam int FRAC_BITS    = 16;
    localparam int ACC_W        = 31;
    localparam int TAB_W        = 30;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    localparam int LANE_STAGES  = 3;
    localparam int MERGE_STAGES = 4;
    localparam int EXP_STAGES   = FRAC_BITS;
    localparam int PIPE_DEPTH   = LANE_STAGES + MERGE_STAGES + EXP_STAGES;

    typedef enum logic [2:0] {
        CFG_MEAN    = 3'd0,
        CFG_PREC    = 3'd1,
        CFG_ROWS    = 3'd2,
        CFG_COLS    = 3'd3,
        CFG_ROW_WIN = 3'd4,
        CFG_COL_WIN = 3'd5
    } t_cfg_index;

    typedef logic [TERM_W-1:0] t_term_vec [COMP_MAX];
    typedef logic [TAB_W-1:0]  t_exp_tab  [FRAC_BITS];

    typedef struct packed {
        logic                 zero;
        logic [4:0]           shift_n;
        logic [FRAC_BITS-1:0] frac;
    } t_exp_arg;

    typedef struct packed {
        logic valid;
        logic border;
        logic last;
    } t_side;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] one_bit;
        logic [63:0] rem;
        res     = '0;
        rem     = v;
        one_bit = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + one_bit) begin
                rem = rem - (res + one_bit);
                res = (res >> 1) + one_bit;
            end else begin
                res = res >> 1;
            end
            one_bit = one_bit >> 2;
        end
        return res;
    endfunction

    // Entry k holds 2^(-2^-(k+1)) in Q0.30, by repeated square roots.
    function automatic t_exp_tab exp_table();
        t_exp_tab    tab;
        logic [63:0] t;
        t = 64'd1 << 29;
        for (int k = 0; k < FRAC_BITS; k++) begin
            t      = isqrt64(t << 30);
            tab[k] = t[TAB_W-1:0];
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pgl_lane.sv =====
// One component lane: difference from the mean, square, precision weight.
// Three register stages; uses pgl_pkg.
`default_nettype none

module pgl_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [pgl_pkg::COMP_W-1:0]    i_x,
    input  wire logic [pgl_pkg::COMP_W-1:0]    i_mean,
    input  wire logic [pgl_pkg::COMP_W-1:0]    i_prec,
    output logic      [pgl_pkg::TERM_W-1:0]    o_term
);

    logic [pgl_pkg::COMP_W:0]     n_diff;
    logic [pgl_pkg::COMP_W:0]     n_neg;
    logic [pgl_pkg::COMP_W-1:0]   n_abs;
    logic [pgl_pkg::COMP_W-1:0]   r_abs;
    logic [2*pgl_pkg::COMP_W-1:0] r_sq;
    logic [pgl_pkg::TERM_W-1:0]   r_term;

    always_comb begin
        n_diff = {i_x[pgl_pkg::COMP_W-1], i_x} - {i_mean[pgl_pkg::COMP_W-1], i_mean};
        n_neg  = -n_diff;
        n_abs  = n_diff[pgl_pkg::COMP_W] ? n_neg[pgl_pkg::COMP_W-1:0]
                                         : n_diff[pgl_pkg::COMP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abs  <= n_abs;
            r_sq   <= {{pgl_pkg::COMP_W{1'b0}}, r_abs} * {{pgl_pkg::COMP_W{1'b0}}, r_abs};
            r_term <= {{pgl_pkg::COMP_W{1'b0}}, r_sq}
                    * {{(2*pgl_pkg::COMP_W){1'b0}}, i_prec};
        end
    end

    assign o_term = r_term;

endmodule

`default_nettype wire

// ===== rtl/pgl_merge.sv =====
// Merge stage: sums the lane terms and scales the sum by log2(e).
// Four register stages; emits the base-2 exponent split for pgl_exp; uses pgl_pkg.
`default_nettype none

module pgl_merge (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire pgl_pkg::t_term_vec   i_terms,
    output pgl_pkg::t_exp_arg         o_arg
);

    localparam int LO_W = 17;
    localparam int HI_W = pgl_pkg::EXP_LIMIT_W - LO_W;

    logic [pgl_pkg::TERM_W:0]   r_pair0;
    logic [pgl_pkg::TERM_W:0]   r_pair1;
    logic [pgl_pkg::SUM_W-1:0]  r_sum;
    logic                       r_zero_pp;
    logic [LO_W+30:0]           r_pp_lo;
    logic [HI_W+30:0]           r_pp_hi;
    logic [63:0]                n_prod;
    pgl_pkg::t_exp_arg          r_arg;

    assign n_prod = {16'd0, r_pp_lo} + {r_pp_hi, {LO_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pair0   <= {1'b0, i_terms[0]} + {1'b0, i_terms[1]};
            r_pair1   <= {1'b0, i_terms[2]} + {1'b0, i_terms[3]};
            r_sum     <= {1'b0, r_pair0} + {1'b0, r_pair1};
            r_zero_pp <= |r_sum[pgl_pkg::SUM_W-1:pgl_pkg::EXP_LIMIT_W];
            r_pp_lo   <= {31'd0, r_sum[LO_W-1:0]} * {{LO_W{1'b0}}, pgl_pkg::LOG2E_Q30};
            r_pp_hi   <= {31'd0, r_sum[pgl_pkg::EXP_LIMIT_W-1:LO_W]}
                       * {{HI_W{1'b0}}, pgl_pkg::LOG2E_Q30};
            r_arg.zero    <= r_zero_pp;
            r_arg.shift_n <= n_prod[63:59];
            r_arg.frac    <= n_prod[58:43];
        end
    end

    assign o_arg = r_arg;

endmodule

`default_nettype wire

// ===== rtl/pgl_exp.sv =====
// Fixed-point 2^-y unit: one multiply stage per fraction bit, then round and shift.
// Sixteen register stages; factor table from pgl_pkg.
`default_nettype none

module pgl_exp (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire pgl_pkg::t_exp_arg  i_arg,
    output logic [15:0]             o_response
);

    localparam int N  = pgl_pkg::EXP_STAGES;
    localparam int AW = pgl_pkg::ACC_W;
    localparam int TW = pgl_pkg::TAB_W;
    localparam int PW = AW + TW;

    localparam pgl_pkg::t_exp_tab TAB = pgl_pkg::exp_table();
    localparam logic [AW-1:0] ONE = AW'(1) << 30;
    localparam logic [PW-1:0] RND = PW'(1) << 29;

    logic [AW-1:0]       r_acc  [N];
    pgl_pkg::t_exp_arg   r_arg  [N];
    logic [AW-1:0]       n_in   [N];
    pgl_pkg::t_exp_arg   n_arg  [N];
    logic [PW-1:0]       n_prod [N];
    logic [AW-1:0]       n_acc  [N];
    logic [5:0]          n_sh;
    logic [AW-1:0]       n_q;
    logic [AW:0]         n_res;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_in[i]   = (i == 0) ? ONE : r_acc[(i == 0) ? 0 : i - 1];
            n_arg[i]  = (i == 0) ? i_arg : r_arg[(i == 0) ? 0 : i - 1];
            n_prod[i] = {{TW{1'b0}}, n_in[i]} * {{AW{1'b0}}, TAB[i]} + RND;
            n_acc[i]  = n_arg[i].frac[N-1-i] ? n_prod[i][PW-1:30] : n_in[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N; i++) begin
                r_acc[i] <= n_acc[i];
                r_arg[i] <= n_arg[i];
            end
        end
    end

    always_comb begin
        n_sh  = 6'd13 + {1'b0, r_arg[N-1].shift_n};
        n_q   = r_acc[N-1] >> n_sh;
        n_res = ({1'b0, n_q} + {{AW{1'b0}}, 1'b1}) >> 1;
        if (r_arg[N-1].zero) begin
            o_response = 16'd0;
        end else if (|n_res[AW:16]) begin
            o_response = 16'hFFFF;
        end else begin
            o_response = n_res[15:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pixel_gaussian_likelihood.sv =====
// Pixel Gaussian likelihood, top level: config registers, scan counters, lanes, merge, exp.
// An input reaches the master side through the lanes, merge, exp and an output register.
// Throughput: one pixel per cycle; the whole pipeline holds while a result waits.
// Reset clears scan counters and pipeline valid flags, and returns the config to defaults.
// Depends on pgl_pkg, pgl_lane, pgl_merge, pgl_exp.
`default_nettype none

module pixel_gaussian_likelihood (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // comp_0, comp_1, comp_2, comp_3
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // response
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    logic [63:0]  r_mean;
    logic [63:0]  r_prec;
    logic [12:0]  r_image_rows;
    logic [12:0]  r_image_cols;
    logic [7:0]   r_row_window;
    logic [7:0]   r_col_window;
    logic [11:0]  r_row;
    logic [11:0]  r_col;

    logic         n_adv;
    logic         n_accept;
    logic [12:0]  n_rows;
    logic [12:0]  n_cols;
    logic [7:0]   n_rw_m1;
    logic [7:0]   n_cw_m1;
    logic [12:0]  n_rm;
    logic [12:0]  n_cm;
    logic [12:0]  n_row13;
    logic [12:0]  n_col13;
    logic         n_border;
    logic         n_last_col;
    logic         n_last_row;

    pgl_pkg::t_side     r_side [pgl_pkg::PIPE_DEPTH];
    pgl_pkg::t_term_vec n_terms;
    pgl_pkg::t_exp_arg  n_arg;
    logic [15:0]        n_exp_resp;

    logic         r_out_valid;
    logic [15:0]  r_out_resp;
    logic         r_out_last;

    assign n_adv         = !r_out_valid || m_axis_tready;
    assign n_accept      = s_axis_tvalid && n_adv;
    assign s_axis_tready = n_adv;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean       <= '0;
            r_prec       <= '0;
            r_image_rows <= 13'd1;
            r_image_cols <= 13'd1;
            r_row_window <= 8'd1;
            r_col_window <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (pgl_pkg::t_cfg_index'(i_cfg_index))
                pgl_pkg::CFG_MEAN:    r_mean       <= i_cfg_data;
                pgl_pkg::CFG_PREC:    r_prec       <= i_cfg_data;
                pgl_pkg::CFG_ROWS:    r_image_rows <= i_cfg_data[12:0];
                pgl_pkg::CFG_COLS:    r_image_cols <= i_cfg_data[12:0];
                pgl_pkg::CFG_ROW_WIN: r_row_window <= i_cfg_data[7:0];
                pgl_pkg::CFG_COL_WIN: r_col_window <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_rows = (r_image_rows == 13'd0) ? 13'd1 :
                 (r_image_rows > 13'd4096) ? 13'd4096 : r_image_rows;
        n_cols = (r_image_cols == 13'd0) ? 13'd1 :
                 (r_image_cols > 13'd4096) ? 13'd4096 : r_image_cols;
        n_rw_m1 = r_row_window - 8'd1;
        n_cw_m1 = r_col_window - 8'd1;
        n_rm = (r_row_window == 8'd0) ? 13'd0 : {6'd0, n_rw_m1[7:1]};
        n_cm = (r_col_window == 8'd0) ? 13'd0 : {6'd0, n_cw_m1[7:1]};
        n_row13 = {1'b0, r_row};
        n_col13 = {1'b0, r_col};
        n_border = (n_col13 < n_cm) || (n_col13 + n_cm >= n_cols) ||
                   (n_row13 < n_rm) || (n_row13 + n_rm >= n_rows);
        n_last_col = (n_col13 + 13'd1 >= n_cols);
        n_last_row = (n_row13 + 13'd1 >= n_rows);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (n_accept) begin
            if (n_last_col) begin
                r_col <= '0;
                r_row <= n_last_row ? 12'd0 : r_row + 12'd1;
            end else begin
                r_col <= r_col + 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pgl_pkg::PIPE_DEPTH; i++) begin
                r_side[i] <= '0;
            end
        end else if (n_adv) begin
            r_side[0] <= '{valid: s_axis_tvalid, border: n_border,
                           last: n_last_col && n_last_row};
            for (int i = 1; i < pgl_pkg::PIPE_DEPTH; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    for (genvar c = 0; c < pgl_pkg::COMP_MAX; c++) begin : g_lane
        if (c < pgl_pkg::COMPONENTS) begin : g_used
            pgl_lane u_lane (
                .i_clk  (i_clk),
                .i_en   (n_adv),
                .i_x    (s_axis_tdata[c*pgl_pkg::COMP_W +: pgl_pkg::COMP_W]),
                .i_mean (r_mean[c*pgl_pkg::COMP_W +: pgl_pkg::COMP_W]),
                .i_prec (r_prec[c*pgl_pkg::COMP_W +: pgl_pkg::COMP_W]),
                .o_term (n_terms[c])
            );
        end else begin : g_unused
            assign n_terms[c] = '0;
        end
    end

    pgl_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (n_adv),
        .i_terms (n_terms),
        .o_arg   (n_arg)
    );

    pgl_exp u_exp (
        .i_clk      (i_clk),
        .i_en       (n_adv),
        .i_arg      (n_arg),
        .o_response (n_exp_resp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_adv) begin
            r_out_valid <= r_side[pgl_pkg::PIPE_DEPTH-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_out_resp <= r_side[pgl_pkg::PIPE_DEPTH-1].border ? 16'hFFFF : n_exp_resp;
            r_out_last <= r_side[pgl_pkg::PIPE_DEPTH-1].last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_resp;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/pgl_checker.sv =====
// Port-level checks for pixel_gaussian_likelihood, bound to the top level.
// Sees only top-level ports; no package dependency.
`default_nettype none

module pgl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind pixel_gaussian_likelihood pgl_checker u_pgl_checker (.*);

`default_nettype wire
